// ===== rtl/core/tmf_pkg.sv =====
// shared types, codes and constants of the telemetry message framer
// no dependencies; imported by every module of the block
package tmf_pkg;

  localparam int ID_W       = 8;
  localparam int SCALE_W    = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int V1_W       = 33;
  localparam int V_W        = 32;

  // message body: id byte plus up to twelve value bytes
  localparam int BODY_BYTES = 13;
  localparam int LEN_W      = $clog2(BODY_BYTES + 1);

  // rpm period numerator is period_scale * 60, below 2^30
  localparam logic [5:0] PERIOD_MULT = 6'd60;
  localparam int NUM_W      = SCALE_W + 6;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // unsigned divide by ten of a 32-bit word: (v * RECIP_10) >> 35 is exact
  localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;
  localparam int RECIP_10_SHIFT   = 35;

  // brake scale 500 / max bar with max bar 200 reduces to 5 / 2
  localparam logic [2:0] BRAKE_MUL = 3'd5;

  localparam logic [7:0] STEER_TAG = 8'h03;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CMD_TIME,
    CMD_SPEED,
    CMD_RPM,
    CMD_POSITION,
    CMD_THROTTLE,
    CMD_STEERING,
    CMD_ACCEL,
    CMD_BRAKE
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMESTAMP_ID,
    CFG_SPEED_ID,
    CFG_RPM_ID,
    CFG_POSITION_ID,
    CFG_THROTTLE_ID,
    CFG_STEERING_ID,
    CFG_ACCEL_ID,
    CFG_PERIOD_SCALE
  } cfg_idx_t;

  typedef struct packed {
    logic [BODY_BYTES-1:0][7:0] body;
    logic [LEN_W-1:0]           len;
  } msg_t;

  typedef struct packed {
    logic valid;
    msg_t msg;
  } push_t;

  // sign-flag q7.8: flag set only for positive values, magnitude bits follow
  function automatic logic [15:0] q78(input logic [31:0] raw);
    logic        pos;
    logic [14:0] mag;
    pos = !raw[31] && (raw != '0);
    mag = raw[31] ? (15'd0 - raw[14:0]) : raw[14:0];
    return {pos, mag[14:8], mag[7:0]};
  endfunction

endpackage

// ===== rtl/core/tmf_div.sv =====
// restoring divider for the rpm period, one quotient bit per cycle
// depends on tmf_pkg
module tmf_div
  import tmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [V_W-1:0]   den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [V_W-1:0]       rem_r, rem_nxt;
  logic [V_W-1:0]       den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [V_W:0]         trial;
  logic [V_W:0]         diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits the low word
      rem_nxt = ge ? diff[V_W-1:0] : trial[V_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

`ifndef SYNTHESIS
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("divider did not start");
  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("divider busy and done together");
`endif

endmodule

// ===== rtl/core/tmf_front.sv =====
// front end: config registers, item register and message formatting
// depends on tmf_pkg and tmf_div
module tmf_front
  import tmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_command,
  input  logic signed [V1_W-1:0] in_first_value,
  input  logic signed [V_W-1:0] in_second_value,
  input  logic signed [V_W-1:0] in_third_value,
  input  logic                  q_full,
  output push_t                 push
);

  logic [6:0][ID_W-1:0] ids_r;
  logic [SCALE_W-1:0]   period_scale_r;

  cmd_t             cmd_r;
  logic [V_W-1:0]   v1_r, v2_r, v3_r;
  logic             item_valid_r, item_valid_nxt;

  logic             accept;
  logic             need_div;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;
  logic [NUM_W-1:0] div_num;
  logic [63:0]      prod_time;
  logic [23:0]      t_time;
  logic [23:0]      t_rpm;
  logic [15:0]      t_throttle;
  logic [15:0]      t_steer;
  logic [17:0]      prod_brake;
  logic [15:0]      q_x, q_y;
  msg_t             msg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ids_r          <= '0;
      period_scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMESTAMP_ID: ids_r[CMD_TIME]     <= cfg_data[ID_W-1:0];
        CFG_SPEED_ID:     ids_r[CMD_SPEED]    <= cfg_data[ID_W-1:0];
        CFG_RPM_ID:       ids_r[CMD_RPM]      <= cfg_data[ID_W-1:0];
        CFG_POSITION_ID:  ids_r[CMD_POSITION] <= cfg_data[ID_W-1:0];
        CFG_THROTTLE_ID:  ids_r[CMD_THROTTLE] <= cfg_data[ID_W-1:0];
        CFG_STEERING_ID:  ids_r[CMD_STEERING] <= cfg_data[ID_W-1:0];
        CFG_ACCEL_ID:     ids_r[CMD_ACCEL]    <= cfg_data[ID_W-1:0];
        CFG_PERIOD_SCALE: period_scale_r      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign need_div   = (cmd_r == CMD_RPM) && (v1_r != '0);
  assign push.valid = item_valid_r && (!need_div || div_done) && !q_full;
  assign in_ready   = !item_valid_r || push.valid;
  assign accept     = in_valid && in_ready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (accept) begin
      item_valid_nxt = 1'b1;
    end else if (push.valid) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_command);
      v1_r  <= in_first_value[V_W-1:0];
      v2_r  <= in_second_value;
      v3_r  <= in_third_value;
    end
  end

  assign div_num = NUM_W'(period_scale_r * PERIOD_MULT);

  tmf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && (in_command == CMD_RPM)),
    .num   (div_num),
    .den   (in_first_value[V_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign prod_time  = v1_r * RECIP_10;
  assign t_time     = prod_time[RECIP_10_SHIFT +: 24];
  // zero rpm sends a zero period
  assign t_rpm      = (v1_r == '0) ? 24'd0 : div_quot[23:0];
  assign t_throttle = 16'(v1_r[15:0] * 6'd50);
  assign t_steer    = 16'(v1_r[15:0] * 4'd10);
  assign prod_brake = 18'(v1_r[16:0] * BRAKE_MUL);
  assign q_x        = q78(v1_r);
  assign q_y        = q78(v2_r);

  always_comb begin
    msg = '0;
    unique case (cmd_r)
      CMD_TIME: begin
        msg.body[0] = ids_r[CMD_TIME];
        msg.body[1] = t_time[23:16];
        msg.body[2] = t_time[15:8];
        msg.body[3] = t_time[7:0];
        msg.len     = LEN_W'(4);
      end
      CMD_SPEED: begin
        msg.body[0] = ids_r[CMD_SPEED];
        msg.body[1] = v1_r[31:24];
        msg.body[2] = v1_r[23:16];
        msg.body[3] = v1_r[15:8];
        msg.body[4] = v1_r[7:0];
        msg.body[5] = 8'h00;
        msg.body[6] = v2_r[23:16];
        msg.body[7] = v2_r[15:8];
        msg.body[8] = v2_r[7:0];
        msg.len     = LEN_W'(9);
      end
      CMD_RPM: begin
        msg.body[0] = ids_r[CMD_RPM];
        msg.body[1] = t_rpm[23:16];
        msg.body[2] = t_rpm[15:8];
        msg.body[3] = t_rpm[7:0];
        msg.len     = LEN_W'(4);
      end
      CMD_POSITION: begin
        msg.body[0]  = ids_r[CMD_POSITION];
        msg.body[1]  = v1_r[31:24];
        msg.body[2]  = v1_r[23:16];
        msg.body[3]  = v1_r[15:8];
        msg.body[4]  = v1_r[7:0];
        msg.body[5]  = v2_r[31:24];
        msg.body[6]  = v2_r[23:16];
        msg.body[7]  = v2_r[15:8];
        msg.body[8]  = v2_r[7:0];
        msg.body[9]  = v3_r[31:24];
        msg.body[10] = v3_r[23:16];
        msg.body[11] = v3_r[15:8];
        msg.body[12] = v3_r[7:0];
        msg.len      = LEN_W'(13);
      end
      CMD_THROTTLE: begin
        msg.body[0] = ids_r[CMD_THROTTLE];
        msg.body[1] = t_throttle[15:8];
        msg.body[2] = t_throttle[7:0];
        msg.len     = LEN_W'(3);
      end
      CMD_STEERING: begin
        // low byte goes out before high byte here
        msg.body[0] = ids_r[CMD_STEERING];
        msg.body[1] = STEER_TAG;
        msg.body[2] = t_steer[7:0];
        msg.body[3] = t_steer[15:8];
        msg.len     = LEN_W'(4);
      end
      CMD_ACCEL: begin
        msg.body[0] = ids_r[CMD_ACCEL];
        msg.body[1] = q_x[15:8];
        msg.body[2] = q_x[7:0];
        msg.body[3] = q_y[15:8];
        msg.body[4] = q_y[7:0];
        msg.len     = LEN_W'(5);
      end
      CMD_BRAKE: begin
        // brake shares the throttle id
        msg.body[0] = ids_r[CMD_THROTTLE];
        msg.body[1] = prod_brake[16:9];
        msg.body[2] = prod_brake[8:1];
        msg.len     = LEN_W'(3);
      end
    endcase
  end

  assign push.msg = msg;

`ifndef SYNTHESIS
  a_wait_divider: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && need_div && !div_done |-> !in_ready && !push.valid)
    else $error("rpm item left before its quotient was ready");
`endif

endmodule

// ===== rtl/core/tmf_back.sv =====
// back end: message queue, byte serializer with running checksum, output register
// depends on tmf_pkg
module tmf_back
  import tmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       q_full,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  msg_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  msg_t              head;
  logic              out_load;
  logic              is_sum;
  logic              pop;
  logic [7:0]        cur_byte;

  assign head     = q_mem[rd_ptr_r];
  assign q_full   = cnt_r == QCNT_W'(QDEPTH);
  assign out_load = (cnt_r != '0) && (!out_valid_r || out_ready);
  assign is_sum   = idx_r == head.len;
  assign cur_byte = is_sum ? sum_r : head.body[idx_r];
  assign pop      = out_load && is_sum;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    if (out_load) begin
      if (is_sum) begin
        idx_nxt = '0;
        sum_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
        sum_nxt = sum_r + cur_byte;
      end
    end
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_mem[wr_ptr_r] <= push.msg;
    end
    if (out_load) begin
      out_byte_r <= cur_byte;
      out_last_r <= is_sum;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("message queue overfilled");
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> idx_r <= head.len)
    else $error("byte index ran past message length");
  a_sum_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == '0 && sum_r == '0)
    else $error("serializer did not restart after checksum byte");
`endif

endmodule

// ===== rtl/core/telemetry_message_framer.sv =====
// an accepted item passes the item register, the message queue and the output register
// before its id byte is valid; rpm items with a nonzero reading also wait for the
// bit-serial period divider, and no new item is taken while it runs
// a message with its checksum is 4 to 14 bytes long; a 2-deep queue decouples
// reset: synchronous active-low rst_n clears queue, serializer and handshakes; ids
// reset to 0 and period_scale to 1
module telemetry_message_framer
  import tmf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_command,
  input  logic signed [V1_W-1:0] in_first_value,
  input  logic signed [V_W-1:0]  in_second_value,
  input  logic signed [V_W-1:0]  in_third_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_byte
);

  push_t push;
  logic  q_full;

  tmf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .in_third_value  (in_third_value),
    .q_full          (q_full),
    .push            (push)
  );

  tmf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .q_full        (q_full),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
